// ===== src/coalescing_work_queue_core_defines.svh =====
// Assertion macros for the coalescing work queue core.
// Used by the top level only; expects clk_i and rst_ni in scope.
`ifndef COALESCING_WORK_QUEUE_CORE_DEFINES_SVH
`define COALESCING_WORK_QUEUE_CORE_DEFINES_SVH

// same-cycle implication, ignored while in reset
`define CWQ_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, ignored while in reset
`define CWQ_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/cwq_pkg.sv =====
// Types and codes shared by the coalescing work queue core.
// No dependencies.
`default_nettype none

package cwq_pkg;

  typedef enum logic [1:0] {
    REQ_ADD      = 2'd0,
    REQ_CLAIM    = 2'd1,
    REQ_COMPLETE = 2'd2,
    REQ_RELEASE  = 2'd3
  } req_e;

  typedef enum logic [2:0] {
    STAT_UPDATED   = 3'd0,
    STAT_ADDED     = 3'd1,
    STAT_FULL      = 3'd2,
    STAT_CLAIMED   = 3'd3,
    STAT_NONE      = 3'd4,
    STAT_REMOVED   = 3'd5,
    STAT_NOT_FOUND = 3'd6,
    STAT_RELEASED  = 3'd7
  } status_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SHIFT,
    ST_EMIT
  } state_e;

  // one table entry as held in the entry RAM
  typedef struct packed {
    logic [31:0] db;
    logic [31:0] rel;
    logic [63:0] ptr;
    logic [31:0] xid;
    logic        busy;
    logic [15:0] owner;
  } entry_t;

  localparam int unsigned ENTRY_W = $bits(entry_t);

  typedef struct packed {
    status_e     status;
    logic [31:0] db;
    logic [31:0] rel;
    logic [63:0] ptr;
    logic [31:0] xid;
    logic [4:0]  count;
  } rsp_t;

endpackage

`default_nettype wire

// ===== src/cwq_req_if.sv =====
// Request channel of the coalescing work queue: valid/ready plus request fields.
// No dependencies.
`default_nettype none

interface cwq_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  req_type;
  logic [31:0] db_id;
  logic [31:0] rel_id;
  logic [63:0] undo_ptr;
  logic [31:0] xid_in;
  logic [15:0] wkr_id;

  modport source (
    output valid, req_type, db_id, rel_id, undo_ptr, xid_in, wkr_id,
    input  ready
  );
  modport sink (
    input  valid, req_type, db_id, rel_id, undo_ptr, xid_in, wkr_id,
    output ready
  );
endinterface

`default_nettype wire

// ===== src/cwq_rsp_if.sv =====
// Result channel of the coalescing work queue: valid/ready plus result fields.
// No dependencies.
`default_nettype none

interface cwq_rsp_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [31:0] out_db_id;
  logic [31:0] out_rel_id;
  logic [63:0] out_undo_ptr;
  logic [31:0] out_xid;
  logic [4:0]  out_count;

  modport source (
    output valid, status, out_db_id, out_rel_id, out_undo_ptr, out_xid, out_count,
    input  ready
  );
  modport sink (
    input  valid, status, out_db_id, out_rel_id, out_undo_ptr, out_xid, out_count,
    output ready
  );
endinterface

`default_nettype wire

// ===== src/cwq_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module cwq_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// ===== src/coalescing_work_queue_core.sv =====
// Coalescing work queue: ordered table of work entries keyed by (db, rel).
// Depends on cwq_pkg, cwq_req_if, cwq_rsp_if, cwq_ram and the defines header.
//
//   channel | dir | beat contents
//   req_i   | in  | req_type, db_id, rel_id, undo_ptr, xid_in, wkr_id
//   rsp_o   | out | status, out_db_id, out_rel_id, out_undo_ptr, out_xid, out_count
//
// A request scans the entry RAM one entry per cycle through its single read
// port; add, claim and complete stop at the first hit. Complete then shifts
// the later entries down one per cycle over the same port. Release always
// visits every entry held. No clearing pass after reset: only entries below
// the count are ever read. A finished result sits in the output register; a
// stalled rsp_o only holds the sequencer once the next result is ready.
`default_nettype none
`include "coalescing_work_queue_core_defines.svh"

module coalescing_work_queue_core
  import cwq_pkg::*;
#(
  parameter int unsigned MAX_ITEMS = 16
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  cwq_req_if.sink   req_i,
  cwq_rsp_if.source rsp_o
);

  localparam int unsigned IW = $clog2(MAX_ITEMS);
  localparam int unsigned CW = $clog2(MAX_ITEMS + 1);
  localparam logic [CW-1:0] CNT_MAX = CW'(MAX_ITEMS);

  state_e        state_q, state_d;
  req_e          op_q;
  logic [31:0]   key_db_q, key_rel_q, xid_q;
  logic [63:0]   ptr_q;
  logic [15:0]   wid_q;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [CW-1:0] rd_idx_q, rd_idx_d;
  logic          rd_vld_q, rd_vld_d;
  logic [IW-1:0] cmp_idx_q, cmp_idx_d;
  rsp_t          res_q, res_d;
  rsp_t          out_q, out_d;
  logic          out_vld_q, out_vld_d;

  logic               ram_we, ram_re;
  logic [IW-1:0]      ram_waddr, ram_raddr;
  logic [ENTRY_W-1:0] ram_wdata, ram_rdata;
  entry_t             rd_ent, wr_ent;

  logic req_acc, issue, scan_end, hit, stop_hit, emit_go;
  logic db_eq, rel_eq;
  logic [CW+4:0] cnt_ext;

  cwq_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(MAX_ITEMS)
  ) u_entries (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  assign rd_ent    = entry_t'(ram_rdata);
  assign ram_wdata = ENTRY_W'(wr_ent);

  assign req_i.ready = (state_q == ST_IDLE);
  assign req_acc     = req_i.valid && req_i.ready;

  // compare unit, shared by every request type
  assign db_eq  = (rd_ent.db == key_db_q);
  assign rel_eq = (rd_ent.rel == key_rel_q);
  always_comb begin
    case (op_q)
      REQ_ADD:      hit = db_eq && rel_eq;
      REQ_CLAIM:    hit = !rd_ent.busy && db_eq;
      REQ_COMPLETE: hit = db_eq && rel_eq && (rd_ent.owner == wid_q);
      REQ_RELEASE:  hit = db_eq;
      default:      hit = 1'b0;
    endcase
  end

  assign issue    = (rd_idx_q < cnt_q);
  assign scan_end = !rd_vld_q && !issue;
  assign stop_hit = rd_vld_q && hit && (op_q != REQ_RELEASE);
  assign emit_go  = !out_vld_q || rsp_o.ready;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (req_acc) state_d = ST_SCAN;
      end
      ST_SCAN: begin
        if (stop_hit) begin
          state_d = (op_q == REQ_COMPLETE) ? ST_SHIFT : ST_EMIT;
        end else if (scan_end) begin
          state_d = ST_EMIT;
        end
      end
      ST_SHIFT: begin
        if (scan_end) state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (emit_go) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // datapath and RAM control
  always_comb begin
    ram_re    = 1'b0;
    ram_raddr = rd_idx_q[IW-1:0];
    ram_we    = 1'b0;
    ram_waddr = cmp_idx_q;
    wr_ent    = rd_ent;
    rd_idx_d  = rd_idx_q;
    rd_vld_d  = 1'b0;
    cmp_idx_d = cmp_idx_q;
    cnt_d     = cnt_q;
    res_d     = res_q;
    out_d     = out_q;
    out_vld_d = out_vld_q;
    cnt_ext   = {5'd0, cnt_q};

    if (out_vld_q && rsp_o.ready) out_vld_d = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (req_acc) begin
          rd_idx_d = '0;
          res_d    = '0;
        end
      end
      ST_SCAN, ST_SHIFT: begin
        ram_re   = issue;
        rd_vld_d = issue;
        if (issue) begin
          rd_idx_d  = rd_idx_q + 1'b1;
          cmp_idx_d = rd_idx_q[IW-1:0];
        end
        if (state_q == ST_SCAN) begin
          if (rd_vld_q && hit) begin
            case (op_q)
              REQ_ADD: begin
                ram_we       = 1'b1;
                wr_ent.ptr   = ptr_q;
                wr_ent.xid   = xid_q;
                res_d.status = STAT_UPDATED;
              end
              REQ_CLAIM: begin
                ram_we       = 1'b1;
                wr_ent.busy  = 1'b1;
                wr_ent.owner = wid_q;
                res_d.status = STAT_CLAIMED;
                res_d.db     = rd_ent.db;
                res_d.rel    = rd_ent.rel;
                res_d.ptr    = rd_ent.ptr;
                res_d.xid    = rd_ent.xid;
              end
              REQ_RELEASE: begin
                ram_we      = 1'b1;
                wr_ent.busy = 1'b0;
              end
              default: ;
            endcase
          end else if (scan_end) begin
            case (op_q)
              REQ_ADD: begin
                if (cnt_q < CNT_MAX) begin
                  ram_we       = 1'b1;
                  ram_waddr    = cnt_q[IW-1:0];
                  wr_ent       = '{db: key_db_q, rel: key_rel_q, ptr: ptr_q,
                                   xid: xid_q, busy: 1'b0, owner: 16'd0};
                  cnt_d        = cnt_q + 1'b1;
                  res_d.status = STAT_ADDED;
                end else begin
                  res_d.status = STAT_FULL;
                end
              end
              REQ_CLAIM:    res_d.status = STAT_NONE;
              REQ_COMPLETE: res_d.status = STAT_NOT_FOUND;
              REQ_RELEASE:  res_d.status = STAT_RELEASED;
              default:      res_d.status = STAT_NONE;
            endcase
          end
        end else begin
          // shift down: the entry read last cycle moves one place lower
          if (rd_vld_q) begin
            ram_we    = 1'b1;
            ram_waddr = cmp_idx_q - 1'b1;
          end
          if (scan_end) begin
            cnt_d        = cnt_q - 1'b1;
            res_d.status = STAT_REMOVED;
          end
        end
      end
      ST_EMIT: begin
        if (emit_go) begin
          out_d       = res_q;
          out_d.count = cnt_ext[4:0];
          out_vld_d   = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      cnt_q     <= '0;
      rd_idx_q  <= '0;
      rd_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      rd_idx_q  <= rd_idx_d;
      rd_vld_q  <= rd_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_acc) begin
      op_q      <= req_e'(req_i.req_type);
      key_db_q  <= req_i.db_id;
      key_rel_q <= req_i.rel_id;
      ptr_q     <= req_i.undo_ptr;
      xid_q     <= req_i.xid_in;
      wid_q     <= req_i.wkr_id;
    end
    cmp_idx_q <= cmp_idx_d;
    res_q     <= res_d;
    out_q     <= out_d;
  end

  assign rsp_o.valid        = out_vld_q;
  assign rsp_o.status       = out_q.status;
  assign rsp_o.out_db_id    = out_q.db;
  assign rsp_o.out_rel_id   = out_q.rel;
  assign rsp_o.out_undo_ptr = out_q.ptr;
  assign rsp_o.out_xid      = out_q.xid;
  assign rsp_o.out_count    = out_q.count;

  `CWQ_ASSERT_IMP(a_cnt_bound, 1'b1, cnt_q <= CNT_MAX, "entry count above capacity")
  `CWQ_ASSERT_NXT(a_accept_scan, req_acc, state_q == ST_SCAN,
                  "accepted beat did not start a scan")
  `CWQ_ASSERT_IMP(a_no_rw_clash, ram_we && ram_re, ram_waddr != ram_raddr,
                  "RAM read and write hit one entry")
  `CWQ_ASSERT_IMP(a_zero_fields, out_vld_q && (out_q.status != STAT_CLAIMED),
                  (out_q.db == 32'd0) && (out_q.ptr == 64'd0) && (out_q.xid == 32'd0),
                  "unclaimed result carries entry data")

endmodule

`default_nettype wire

// ===== test/cwq_tb_pkg.sv =====
// Scoreboard for the coalescing work queue testbench: a table model and result store.
// Depends on cwq_pkg.
`default_nettype none

package cwq_tb_pkg;
  import cwq_pkg::*;

  localparam int unsigned TABLE_DEPTH = 16;

  typedef struct packed {
    req_e        kind;
    logic [31:0] db;
    logic [31:0] rel;
    logic [63:0] ptr;
    logic [31:0] xid;
    logic [15:0] worker;
  } work_req_t;

  class work_queue_model;
    entry_t      slots[TABLE_DEPTH];
    int unsigned held;
    rsp_t        due_results[$];
    int unsigned errors;
    int unsigned checked;
    int unsigned outcome_seen[8];

    function new();
      held = 0;
      errors = 0;
      checked = 0;
      foreach (outcome_seen[i]) outcome_seen[i] = 0;
    endfunction

    // apply one accepted request to the table and queue the result it gives
    function void note_request(work_req_t r);
      rsp_t        want;
      bit          found;
      int unsigned i;
      int unsigned j;
      want = '0;
      found = 1'b0;
      case (r.kind)
        REQ_ADD: begin
          for (i = 0; i < held && !found; i++) begin
            if (slots[i].db == r.db && slots[i].rel == r.rel) begin
              slots[i].ptr = r.ptr;
              slots[i].xid = r.xid;
              found = 1'b1;
            end
          end
          if (found) begin
            want.status = STAT_UPDATED;
          end else if (held >= TABLE_DEPTH) begin
            want.status = STAT_FULL;
          end else begin
            slots[held] = '{db: r.db, rel: r.rel, ptr: r.ptr, xid: r.xid,
                            busy: 1'b0, owner: 16'h0};
            held++;
            want.status = STAT_ADDED;
          end
        end
        REQ_CLAIM: begin
          want.status = STAT_NONE;
          for (i = 0; i < held && !found; i++) begin
            if (!slots[i].busy && slots[i].db == r.db) begin
              want.db = slots[i].db;
              want.rel = slots[i].rel;
              want.ptr = slots[i].ptr;
              want.xid = slots[i].xid;
              slots[i].busy = 1'b1;
              slots[i].owner = r.worker;
              want.status = STAT_CLAIMED;
              found = 1'b1;
            end
          end
        end
        REQ_COMPLETE: begin
          want.status = STAT_NOT_FOUND;
          for (i = 0; i < held && !found; i++) begin
            if (slots[i].db == r.db && slots[i].rel == r.rel &&
                slots[i].owner == r.worker) begin
              for (j = i; j + 1 < held; j++) slots[j] = slots[j + 1];
              held--;
              want.status = STAT_REMOVED;
              found = 1'b1;
            end
          end
        end
        default: begin
          for (i = 0; i < held; i++) begin
            if (slots[i].db == r.db) slots[i].busy = 1'b0;
          end
          want.status = STAT_RELEASED;
        end
      endcase
      want.count = held[4:0];
      outcome_seen[want.status]++;
      due_results.push_back(want);
    endfunction

    function void match_field(string field, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
        $error("%s: expected %0h, got %0h", field, want, got);
        errors++;
      end
    endfunction

    function void check_result(rsp_t got);
      rsp_t want;
      if (due_results.size() == 0) begin
        $error("result beat with nothing outstanding (status %0h)", got.status);
        errors++;
        return;
      end
      want = due_results.pop_front();
      checked++;
      match_field("status", want.status, got.status);
      match_field("out_db_id", want.db, got.db);
      match_field("out_rel_id", want.rel, got.rel);
      match_field("out_undo_ptr", want.ptr, got.ptr);
      match_field("out_xid", want.xid, got.xid);
      match_field("out_count", want.count, got.count);
    endfunction

    function int unsigned outstanding();
      return due_results.size();
    endfunction

    // a live entry, so completes can hit real (db, rel, owner) triples
    function bit pick_live(output entry_t e);
      e = '0;
      if (held == 0) return 1'b0;
      e = slots[$urandom_range(0, held - 1)];
      return 1'b1;
    endfunction
  endclass

endpackage

`default_nettype wire

// ===== test/coalescing_work_queue_core_tb.sv =====
// Testbench top for coalescing_work_queue_core: directed and random request streams.
// Depends on cwq_pkg, cwq_req_if, cwq_rsp_if, cwq_tb_pkg and the core itself.
`default_nettype none

module coalescing_work_queue_core_tb;
  import cwq_pkg::*;
  import cwq_tb_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned STALL_LIMIT = 5000;
  localparam int unsigned PHASES = 16;
  localparam int unsigned PHASE_ITEMS = 120;

  logic clk_i = 1'b0;
  logic rst_ni;

  cwq_req_if req_if ();
  cwq_rsp_if rsp_if ();

  coalescing_work_queue_core #(
    .MAX_ITEMS(TABLE_DEPTH)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_if),
    .rsp_o (rsp_if)
  );

  always #1 clk_i = ~clk_i;

  work_queue_model board;
  bit              steady;
  int unsigned     idle_cycles;
  logic [31:0]     db_pool[4];
  logic [31:0]     rel_pool[6];
  logic [15:0]     wid_pool[4];

  // mostly short gaps, now and then a long one
  function automatic int unsigned gap_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (steady || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic void refresh_pools();
    foreach (db_pool[i]) db_pool[i] = $urandom;
    foreach (rel_pool[i]) rel_pool[i] = $urandom;
    foreach (wid_pool[i]) wid_pool[i] = 16'($urandom);
    wid_pool[0] = 16'h0;
    if ($urandom_range(0, 2) == 0) db_pool[1] = 32'h0;
    if ($urandom_range(0, 2) == 0) db_pool[2] = 32'hFFFF_FFFF;
  endfunction

  function automatic work_req_t make_req(int unsigned add_pct, int unsigned claim_pct,
                                         int unsigned complete_pct);
    work_req_t   r;
    entry_t      e;
    int unsigned pick;
    r.db = db_pool[$urandom_range(0, 3)];
    r.rel = rel_pool[$urandom_range(0, 5)];
    r.ptr = {$urandom, $urandom};
    r.xid = $urandom;
    r.worker = wid_pool[$urandom_range(0, 3)];
    pick = $urandom_range(0, 99);
    if ($urandom_range(0, 99) < 8) begin
      // noise: every field drawn from its whole range
      r.kind = req_e'($urandom_range(0, 3));
      r.db = $urandom;
      r.rel = $urandom;
      r.worker = 16'($urandom);
    end else if (pick < add_pct) begin
      r.kind = REQ_ADD;
    end else if (pick < add_pct + claim_pct) begin
      r.kind = REQ_CLAIM;
    end else if (pick < add_pct + claim_pct + complete_pct) begin
      r.kind = REQ_COMPLETE;
      if ($urandom_range(0, 9) < 7 && board.pick_live(e)) begin
        r.db = e.db;
        r.rel = e.rel;
        r.worker = e.owner;
      end
    end else begin
      r.kind = REQ_RELEASE;
    end
    return r;
  endfunction

  // drive one request beat; valid stays high when the next beat follows at once
  task automatic send_req(work_req_t r);
    int unsigned g;
    req_if.valid <= 1'b1;
    req_if.req_type <= r.kind;
    req_if.db_id <= r.db;
    req_if.rel_id <= r.rel;
    req_if.undo_ptr <= r.ptr;
    req_if.xid_in <= r.xid;
    req_if.wkr_id <= r.worker;
    do @(posedge clk_i); while (!req_if.ready);
    board.note_request(r);
    g = gap_len();
    if (g != 0) begin
      req_if.valid <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
  endtask

  task automatic send_fields(req_e kind, logic [31:0] db, logic [31:0] rel,
                             logic [63:0] ptr, logic [31:0] xid, logic [15:0] worker);
    work_req_t r;
    r = '{kind: kind, db: db, rel: rel, ptr: ptr, xid: xid, worker: worker};
    send_req(r);
  endtask

  task automatic wait_drained();
    req_if.valid <= 1'b0;
    while (board.outstanding() != 0) @(posedge clk_i);
  endtask

  // result side: ready toggles in bursts, held high in steady stretches
  initial begin
    int unsigned g;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      rsp_if.ready <= 1'b1;
      if (steady) begin
        @(posedge clk_i);
      end else begin
        repeat ($urandom_range(1, 6)) @(posedge clk_i);
        g = gap_len();
        if (g != 0) begin
          rsp_if.ready <= 1'b0;
          repeat (g) @(posedge clk_i);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    rsp_t got;
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      got.status = status_e'(rsp_if.status);
      got.db = rsp_if.out_db_id;
      got.rel = rsp_if.out_rel_id;
      got.ptr = rsp_if.out_undo_ptr;
      got.xid = rsp_if.out_xid;
      got.count = rsp_if.out_count;
      board.check_result(got);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni !== 1'b1) begin
      idle_cycles <= 0;
    end else if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("coalescing_work_queue_core verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int unsigned k;
    int unsigned p;
    board = new();
    steady = 1'b0;
    rst_ni = 1'b0;
    req_if.valid = 1'b0;
    req_if.req_type = REQ_ADD;
    req_if.db_id = '0;
    req_if.rel_id = '0;
    req_if.undo_ptr = '0;
    req_if.xid_in = '0;
    req_if.wkr_id = '0;
    rsp_if.ready = 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty table: nothing to claim, nothing to remove, release of no entries
    send_fields(REQ_CLAIM, 32'h0, 32'h0, '0, '0, 16'h0);
    send_fields(REQ_COMPLETE, 32'h0, 32'h0, '0, '0, 16'h0);
    send_fields(REQ_RELEASE, 32'hFFFF_FFFF, '0, '0, '0, 16'hFFFF);
    send_fields(REQ_ADD, 32'h0, 32'h0, 64'h0, 32'h0, 16'h0);
    send_fields(REQ_ADD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, '1, 32'hFFFF_FFFF, 16'hFFFF);
    send_fields(REQ_ADD, 32'h0, 32'h0, 64'h5555_AAAA_5555_AAAA, 32'hA5A5_5A5A, 16'h0);
    send_fields(REQ_CLAIM, 32'hFFFF_FFFF, '0, '0, '0, 16'hFFFF);
    // update of a busy entry keeps the busy mark, so a second claim finds nothing
    send_fields(REQ_ADD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 64'h0123_4567_89AB_CDEF,
                32'h1357_9BDF, 16'h0);
    send_fields(REQ_CLAIM, 32'hFFFF_FFFF, '0, '0, '0, 16'h0001);
    send_fields(REQ_RELEASE, 32'hFFFF_FFFF, '0, '0, '0, 16'h0);
    send_fields(REQ_CLAIM, 32'hFFFF_FFFF, '0, '0, '0, 16'h0001);
    // owner is now 1, so the old worker misses
    send_fields(REQ_COMPLETE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, '0, '0, 16'hFFFF);
    // worker zero removes an entry that was never claimed
    send_fields(REQ_COMPLETE, 32'h0, 32'h0, '0, '0, 16'h0);
    for (k = 1; k < TABLE_DEPTH; k++)
      send_fields(REQ_ADD, 32'h0000_1234, k, {$urandom, $urandom}, $urandom, 16'h0);
    send_fields(REQ_ADD, 32'h0000_1234, TABLE_DEPTH, '1, '1, 16'h0);
    wait_drained();

    for (p = 0; p < PHASES; p++) begin
      refresh_pools();
      steady = (p % 5 == 2);
      for (k = 0; k < PHASE_ITEMS; k++) begin
        case (p % 4)
          0: send_req(make_req(55, 20, 15));
          1: send_req(make_req(35, 30, 25));
          2: send_req(make_req(15, 30, 45));
          default: send_req(make_req(30, 40, 20));
        endcase
      end
      if (p % 3 == 0) wait_drained();
    end

    wait_drained();
    repeat (60) @(posedge clk_i);
    if (board.outstanding() != 0) begin
      $error("%0d expected results never arrived", board.outstanding());
      board.errors++;
    end
    $display("checked %0d results: %0d added, %0d updated, %0d full, %0d claimed,",
             board.checked, board.outcome_seen[STAT_ADDED],
             board.outcome_seen[STAT_UPDATED], board.outcome_seen[STAT_FULL],
             board.outcome_seen[STAT_CLAIMED]);
    $display("  %0d nothing to claim, %0d removed, %0d not found, %0d released",
             board.outcome_seen[STAT_NONE], board.outcome_seen[STAT_REMOVED],
             board.outcome_seen[STAT_NOT_FOUND], board.outcome_seen[STAT_RELEASED]);
    if (board.errors == 0) begin
      $display("coalescing_work_queue_core verification clean");
    end else begin
      $display("coalescing_work_queue_core verification failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
